// ===== sv/hashed_next_hop_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// hashed next-hop table assertion macros
// shared concurrent assertion wrappers for the table rtl
// ----------------------------------------------------------------------------
`ifndef HASHED_NEXT_HOP_TABLE_TOP_DEFINES_SVH
`define HASHED_NEXT_HOP_TABLE_TOP_DEFINES_SVH

// assertion that is switched off while reset is asserted
`define HNH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// assertion that must also hold while reset is asserted
`define HNH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hnh_pkg.sv =====
// ----------------------------------------------------------------------------
// hnh_pkg
// shared field widths, command codes and result type of the next-hop table
// ----------------------------------------------------------------------------
`default_nettype none

package hnh_pkg;

  // width of the id fields on the channels
  localparam int unsigned ID_W = 16;

  typedef enum logic {
    CMD_SET    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] next_hop_out;
    logic            table_full;
  } hnh_result_t;

endpackage

`default_nettype wire

// ===== sv/hnh_if.sv =====
// ----------------------------------------------------------------------------
// hnh channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface hnh_in_if import hnh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [ID_W-1:0] dest_id;
  logic [ID_W-1:0] next_hop_in;

  modport source (output valid, command, dest_id, next_hop_in, input ready);
  modport sink   (input valid, command, dest_id, next_hop_in, output ready);
endinterface

interface hnh_out_if import hnh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] next_hop_out;
  logic            table_full;

  modport source (output valid, found, next_hop_out, table_full, input ready);
  modport sink   (input valid, found, next_hop_out, table_full, output ready);
endinterface

`default_nettype wire

// ===== sv/hashed_next_hop_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_next_hop_table_top
// destination-to-next-hop routing table with fixed ways per hashed bucket
// ----------------------------------------------------------------------------
// usage
//   in_i carries command items: command (set or look up), dest_id, next_hop_in
//   out_o carries one result item per command: found, next_hop_out, table_full
//   bucket of a key is key mod SLOTS, each bucket holds up to WAYS entries
//   the front finds the bucket with a reciprocal multiply, then a multiply
//   back and subtract; the quotient is registered before the subtract
//   the back reads one bucket row, compares all ways and writes back
//   front and back each take a new item only once the last one is handed on
//   after reset a clearing pass over every bucket zeroes its fill count;
//   in_i.ready stays low until it completes
//   a stalled receiver holds the result register; the two-entry queue between
//   front and back keeps accepting until it fills, and once the front also holds an item in_i.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_next_hop_table_top import hnh_pkg::*; #(
  parameter int unsigned SLOTS   = 16,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned ID_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hnh_in_if.sink    in_i,
  hnh_out_if.source out_o
);

  // stored key and next-hop width
  localparam int unsigned KEY_W   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // queue item: {command, key, next hop, bucket}
  localparam int unsigned ENTRY_W = 1 + 2 * KEY_W + SLOT_W;

  logic               clear_busy;
  logic               q_full;
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_data;

  // front: accept, mask key, compute bucket
  hnh_front #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (q_push_data)
  );

  // decoupling queue
  hnh_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: bucket store, lookup and update, result register
  hnh_back #(
    .SLOTS   (SLOTS),
    .WAYS    (WAYS),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .pop_o        (q_pop),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/hnh_front.sv =====
// ----------------------------------------------------------------------------
// hnh_front
// accepts command items, masks the key and folds it down to its bucket
// ----------------------------------------------------------------------------
`default_nettype none

module hnh_front import hnh_pkg::*; #(
  parameter int unsigned SLOTS   = 16,
  parameter int unsigned ID_BITS = 16,
  localparam int unsigned KEY_W   = (ID_BITS < ID_W) ? ID_BITS : ID_W,
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned ENTRY_W = 1 + 2 * KEY_W + SLOT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  hnh_in_if.sink                  in_i,
  input  wire logic               clear_busy_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output logic [ENTRY_W-1:0]      push_data_o
);

  // reciprocal of SLOTS, exact for every key of KEY_W bits
  localparam int unsigned LOG_SLOTS = $clog2(SLOTS);
  localparam int unsigned SHIFT     = KEY_W + LOG_SLOTS;
  localparam int unsigned RECIP_W   = KEY_W + 2;
  localparam int unsigned PROD_W    = KEY_W + RECIP_W;
  localparam int unsigned MUL_W     = KEY_W + SLOT_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [SLOT_W:0] SLOTS_C = (SLOT_W + 1)'(SLOTS);
  // quotient step, then remainder step
  localparam int unsigned STEPS  = 2;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);

  logic              busy_q;
  logic [STEP_W-1:0] steps_q;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  hop_q;
  logic [KEY_W-1:0]  quot_q;
  logic [SLOT_W-1:0] rem_q;

  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  quot;
  logic [MUL_W-1:0]  back_mul;
  logic [KEY_W-1:0]  rem_full;
  logic [SLOT_W-1:0] rem_step;
  logic [SLOT_W-1:0] push_rem;
  logic              last_step;
  logic              waiting;
  logic              stepping;
  logic              accept;

  // quotient by reciprocal multiply, remainder by multiply back and subtract
  always_comb begin
    prod     = PROD_W'(key_q) * PROD_W'(RECIP);
    quot     = KEY_W'(prod >> SHIFT);
    back_mul = MUL_W'(quot_q) * MUL_W'(SLOTS_C);
    rem_full = key_q - back_mul[KEY_W-1:0];
    rem_step = SLOT_W'(rem_full);
  end

  assign stepping  = busy_q && (steps_q != '0);
  assign last_step = busy_q && (steps_q == STEP_W'(1));
  assign waiting   = busy_q && (steps_q == '0);
  assign push_o    = (last_step || waiting) && !q_full_i;
  assign push_rem  = waiting ? rem_q : rem_step;
  assign push_data_o = {cmd_q, key_q, hop_q, push_rem};

  assign in_i.ready = !clear_busy_i && (!busy_q || push_o);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
    end else if (accept) begin
      busy_q  <= 1'b1;
      steps_q <= STEP_W'(STEPS);
    end else begin
      if (push_o) begin
        busy_q <= 1'b0;
      end
      if (stepping) begin
        steps_q <= steps_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_i.command;
      key_q   <= in_i.dest_id[KEY_W-1:0];
      hop_q   <= in_i.next_hop_in[KEY_W-1:0];
    end else if (stepping) begin
      quot_q  <= quot;
      rem_q   <= rem_step;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hnh_queue.sv =====
// ----------------------------------------------------------------------------
// hnh_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_next_hop_table_top_defines.svh"

module hnh_queue import hnh_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HNH_ASSERT_ALWAYS(a_cnt_range, clk_i, cnt_q <= CNT_W'(DEPTH), "queue count past depth")
  `HNH_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `HNH_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> valid_o, "pop from empty queue")

endmodule

`default_nettype wire

// ===== sv/hnh_back.sv =====
// ----------------------------------------------------------------------------
// hnh_back
// bucket store, clearing pass, way compare, update and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_next_hop_table_top_defines.svh"

module hnh_back import hnh_pkg::*; #(
  parameter int unsigned SLOTS   = 16,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned ID_BITS = 16,
  localparam int unsigned KEY_W   = (ID_BITS < ID_W) ? ID_BITS : ID_W,
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned ENTRY_W = 1 + 2 * KEY_W + SLOT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire logic [ENTRY_W-1:0] q_data_i,
  output logic                    pop_o,
  output logic                    clear_busy_o,
  hnh_out_if.source               out_o
);

  localparam int unsigned CNT_W  = $clog2(WAYS + 1);
  localparam int unsigned HOP_LO = WAYS * KEY_W;
  localparam int unsigned ROW_W  = CNT_W + 2 * WAYS * KEY_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  // row layout: {fill count, next hops, keys}, ways filled from the bottom
  logic [ROW_W-1:0]  mem [SLOTS];
  logic [ROW_W-1:0]  rd_row_q;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] clr_idx_q, clr_idx_d;
  logic              out_valid_q;
  hnh_result_t       out_q;

  cmd_e              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  hop_q;
  logic [SLOT_W-1:0] bucket_q;

  logic [CNT_W-1:0]  rd_cnt;
  logic [KEY_W-1:0]  way_dest;
  logic [KEY_W-1:0]  way_hop;
  logic [KEY_W-1:0]  hit_hop;
  logic              hit;
  logic              has_free;
  logic [ROW_W-1:0]  upd_row;
  logic [ROW_W-1:0]  app_row;
  logic              is_set;
  logic              out_free;
  logic              eval_go;
  hnh_result_t       res;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;

  assign clear_busy_o = (state_q == ST_CLEAR);
  assign pop_o        = (state_q == ST_IDLE) && q_valid_i;
  assign out_free     = !out_valid_q || out_o.ready;
  assign eval_go      = (state_q == ST_EVAL) && out_free;

  // compare all ways of the bucket row at once
  always_comb begin
    rd_cnt   = rd_row_q[ROW_W-1 -: CNT_W];
    hit      = 1'b0;
    hit_hop  = '0;
    way_dest = '0;
    way_hop  = '0;
    upd_row  = rd_row_q;
    app_row  = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      way_dest = rd_row_q[w*KEY_W +: KEY_W];
      way_hop  = rd_row_q[HOP_LO + w*KEY_W +: KEY_W];
      if ((CNT_W'(w) < rd_cnt) && (way_dest == key_q)) begin
        hit     = 1'b1;
        hit_hop = hit_hop | way_hop;
        upd_row[HOP_LO + w*KEY_W +: KEY_W] = hop_q;
      end
      if (CNT_W'(w) == rd_cnt) begin
        app_row[w*KEY_W +: KEY_W]          = key_q;
        app_row[HOP_LO + w*KEY_W +: KEY_W] = hop_q;
      end
    end
    app_row[ROW_W-1 -: CNT_W] = rd_cnt + CNT_W'(1);
    has_free = (rd_cnt < CNT_W'(WAYS));
  end

  always_comb begin
    is_set           = (cmd_q == CMD_SET);
    res.found        = hit;
    res.table_full   = is_set && !hit && !has_free;
    res.next_hop_out = (!is_set && hit) ? ID_W'(hit_hop) : '0;
  end

  // single write port, shared by the clearing pass and set commands
  always_comb begin
    wr_en   = clear_busy_o || (eval_go && is_set && (hit || has_free));
    wr_addr = clear_busy_o ? clr_idx_q : bucket_q;
    wr_data = clear_busy_o ? '0 : (hit ? upd_row : app_row);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (pop_o) begin
      rd_row_q <= mem[q_data_i[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q    <= cmd_e'(q_data_i[ENTRY_W-1]);
      key_q    <= q_data_i[SLOT_W + KEY_W +: KEY_W];
      hop_q    <= q_data_i[SLOT_W +: KEY_W];
      bucket_q <= q_data_i[SLOT_W-1:0];
    end
    if (eval_go) begin
      out_q <= res;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + SLOT_W'(1);
        if (clr_idx_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (eval_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_q.found;
  assign out_o.next_hop_out = out_q.next_hop_out;
  assign out_o.table_full   = out_q.table_full;

  `HNH_ASSERT(a_fill_range, clk_i, rst_ni, (state_q == ST_EVAL) |-> (rd_cnt <= CNT_W'(WAYS)), "bucket fill count out of range")
  `HNH_ASSERT(a_pop_eval, clk_i, rst_ni, pop_o |=> (state_q == ST_EVAL), "popped item not evaluated")
  `HNH_ASSERT(a_eval_out, clk_i, rst_ni, eval_go |=> (out_valid_q && state_q == ST_IDLE), "result not registered")
  `HNH_ASSERT(a_full_clean, clk_i, rst_ni, (out_valid_q && out_q.table_full) |-> (!out_q.found && out_q.next_hop_out == '0), "dropped set with hit fields")

endmodule

`default_nettype wire
